FILE: rtl/core/dobss_pkg.sv
// Shared types, constants and register codes for the DAC offset servo.
`timescale 1ns / 1ps

package dobss_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int STEPS_DEF    = 11;

  localparam int CHAN_W      = 3;
  localparam int SAMPLE_W    = 16;
  localparam int CODE_W      = 12;
  localparam int STEP_IDX_W  = 4;
  localparam int STEP_SIZE_W = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [STEP_SIZE_W-1:0] FIRST_STEP = 11'd1024;
  localparam logic [CODE_W-1:0]      CODE_MAX   = 12'd4095;
  localparam logic [CODE_W-1:0]      RESET_CODE = 12'd2048;

  localparam logic [SAMPLE_W-1:0] SETTLED_UPPER_RST   = 16'd65000;
  localparam logic [SAMPLE_W-1:0] SETTLED_LOWER_RST   = 16'd500;
  localparam logic [SAMPLE_W-1:0] SLEW_DONE_UPPER_RST = 16'd40000;
  localparam logic [SAMPLE_W-1:0] SLEW_DONE_LOWER_RST = 16'd26000;
  localparam logic [SAMPLE_W-1:0] MID_LEVEL_RST       = 16'd32768;

  typedef enum logic {
    CMD_SAMPLE   = 1'b0,
    CMD_OVERRIDE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLED_UPPER   = 3'd0,
    REG_SETTLED_LOWER   = 3'd1,
    REG_SLEW_DONE_UPPER = 3'd2,
    REG_SLEW_DONE_LOWER = 3'd3,
    REG_MID_LEVEL       = 3'd4,
    REG_START_CODE      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] settled_upper;
    logic [SAMPLE_W-1:0] settled_lower;
    logic [SAMPLE_W-1:0] slew_done_upper;
    logic [SAMPLE_W-1:0] slew_done_lower;
    logic [SAMPLE_W-1:0] mid_level;
    logic [CODE_W-1:0]   start_code;
  } cfg_t;

  typedef struct packed {
    logic                  slew;
    logic [STEP_IDX_W-1:0] step;
    logic [CODE_W-1:0]     code;
  } chan_state_t;

endpackage

FILE: rtl/core/dobss_chan_update.sv
// Next-state logic for one channel: binary slew step, settle, restart, override.
`timescale 1ns / 1ps

module dobss_chan_update #(
  parameter int STEPS = dobss_pkg::STEPS_DEF
) (
  input  dobss_pkg::cfg_t                      cfg_i,
  input  dobss_pkg::chan_state_t               cur_i,
  input  logic                                 cmd_i,
  input  logic [dobss_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic [dobss_pkg::CODE_W-1:0]         override_code_i,
  output dobss_pkg::chan_state_t               nxt_o
);
  import dobss_pkg::*;

  logic                   out_slew_win;
  logic                   out_settled_win;
  logic [STEP_SIZE_W-1:0] step_size;
  logic [CODE_W:0]        code_up;
  logic [CODE_W-1:0]      code_stepped;
  chan_state_t            restart_st;
  chan_state_t            settle_st;

  assign out_slew_win    = (sample_i >= cfg_i.slew_done_upper) ||
                           (sample_i <= cfg_i.slew_done_lower);
  assign out_settled_win = (sample_i >= cfg_i.settled_upper) ||
                           (sample_i <= cfg_i.settled_lower);

  assign step_size = FIRST_STEP >> cur_i.step;
  assign code_up   = {1'b0, cur_i.code} + {2'b00, step_size};

  // Saturate the stepped code to the DAC range.
  always_comb begin
    if (sample_i >= cfg_i.mid_level) begin
      if ({1'b0, cur_i.code} < {2'b00, step_size}) begin
        code_stepped = '0;
      end else begin
        code_stepped = cur_i.code - {1'b0, step_size};
      end
    end else if (code_up > {1'b0, CODE_MAX}) begin
      code_stepped = CODE_MAX;
    end else begin
      code_stepped = code_up[CODE_W-1:0];
    end
  end

  assign restart_st = '{slew: 1'b1, step: '0, code: cfg_i.start_code};
  assign settle_st  = '{slew: 1'b0, step: '0, code: cur_i.code};

  always_comb begin
    nxt_o = cur_i;
    if (cmd_e'(cmd_i) == CMD_OVERRIDE) begin
      nxt_o.code = override_code_i;
    end else if (!cur_i.slew) begin
      if (out_settled_win) begin
        nxt_o = restart_st;
      end
    end else if (int'(cur_i.step) >= STEPS) begin
      nxt_o = out_slew_win ? restart_st : settle_st;
    end else if (out_slew_win) begin
      nxt_o.code = code_stepped;
      nxt_o.step = cur_i.step + 1'b1;
    end else begin
      nxt_o = settle_st;
    end
  end

endmodule

FILE: rtl/core/dac_offset_binary_slew_servo.sv
// Top level of the per-channel binary-slew DAC offset servo.
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------------------------
//   in      | in_valid_i / in_ready_o | cmd_i, channel_i, sample_i, override_code_i
//   out     | out_valid_o/out_ready_i | out_channel_o, dac_code_o, slewing_o
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i (always ready)
//
// One beat per cycle unless the output stalls; a beat moves from the input register
// to the result register. The channel state flops are updated on the same edge that
// loads the result register, so beats for the same channel may follow each other in
// every cycle. Reset puts every channel into slewing at code 2048 with step count
// zero and loads the default thresholds. A stalled output holds its beat; the input
// register still drains into the result register once that beat is taken.
`timescale 1ns / 1ps

module dac_offset_binary_slew_servo #(
  parameter int CHANNELS = dobss_pkg::CHANNELS_DEF,
  parameter int STEPS    = dobss_pkg::STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [dobss_pkg::CHAN_W-1:0]       channel_i,
  input  logic [dobss_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic [dobss_pkg::CODE_W-1:0]       override_code_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dobss_pkg::CHAN_W-1:0]       out_channel_o,
  output logic [dobss_pkg::CODE_W-1:0]       dac_code_o,
  output logic                               slewing_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dobss_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dobss_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import dobss_pkg::*;

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t cfg_q;

  logic                  s1_valid_q;
  logic                  s1_cmd_q;
  logic [CHAN_W-1:0]     s1_ch_q;
  logic [SAMPLE_W-1:0]   s1_sample_q;
  logic [CODE_W-1:0]     s1_ov_q;

  logic                  out_valid_q;
  logic [CHAN_W-1:0]     out_ch_q;
  logic [CODE_W-1:0]     out_code_q;
  logic                  out_slew_q;

  logic                  slew_q [CHANNELS];
  logic [STEP_IDX_W-1:0] step_q [CHANNELS];
  logic [CODE_W-1:0]     code_q [CHANNELS];

  logic                  s1_advance;
  logic                  s1_fire;
  logic                  ch_ok;
  logic [IdxW-1:0]       idx;
  chan_state_t           cur_st;
  chan_state_t           nxt_st;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settled_upper   <= SETTLED_UPPER_RST;
      cfg_q.settled_lower   <= SETTLED_LOWER_RST;
      cfg_q.slew_done_upper <= SLEW_DONE_UPPER_RST;
      cfg_q.slew_done_lower <= SLEW_DONE_LOWER_RST;
      cfg_q.mid_level       <= MID_LEVEL_RST;
      cfg_q.start_code      <= RESET_CODE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SETTLED_UPPER:   cfg_q.settled_upper   <= cfg_data_i;
        REG_SETTLED_LOWER:   cfg_q.settled_lower   <= cfg_data_i;
        REG_SLEW_DONE_UPPER: cfg_q.slew_done_upper <= cfg_data_i;
        REG_SLEW_DONE_LOWER: cfg_q.slew_done_lower <= cfg_data_i;
        REG_MID_LEVEL:       cfg_q.mid_level       <= cfg_data_i;
        REG_START_CODE:      cfg_q.start_code      <= cfg_data_i[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 moves on when the result register is empty or drains.
  assign s1_advance = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_advance;
  assign in_ready_o = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q    <= cmd_i;
      s1_ch_q     <= channel_i;
      s1_sample_q <= sample_i;
      s1_ov_q     <= override_code_i;
    end
  end

  // Channel lookup; channels beyond the configured count are ignored.
  assign ch_ok = int'(s1_ch_q) < CHANNELS;
  assign idx   = IdxW'(s1_ch_q);

  assign cur_st = '{slew: slew_q[idx], step: step_q[idx], code: code_q[idx]};

  dobss_chan_update #(
    .STEPS(STEPS)
  ) u_update (
    .cfg_i           (cfg_q),
    .cur_i           (cur_st),
    .cmd_i           (s1_cmd_q),
    .sample_i        (s1_sample_q),
    .override_code_i (s1_ov_q),
    .nxt_o           (nxt_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slew_q[i] <= 1'b1;
        step_q[i] <= '0;
        code_q[i] <= RESET_CODE;
      end
    end else if (s1_fire && ch_ok) begin
      slew_q[idx] <= nxt_st.slew;
      step_q[idx] <= nxt_st.step;
      code_q[idx] <= nxt_st.code;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_ch_q   <= s1_ch_q;
      out_code_q <= ch_ok ? nxt_st.code : '0;
      out_slew_q <= ch_ok ? nxt_st.slew : 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign dac_code_o    = out_code_q;
  assign slewing_o     = out_slew_q;

endmodule

FILE: rtl/core/dobss_checker.sv
// Port-level checks for the DAC offset servo, bound to the top level.
`timescale 1ns / 1ps

module dobss_checker #(
  parameter int CHANNELS = dobss_pkg::CHANNELS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [dobss_pkg::CHAN_W-1:0]       out_channel_o,
  input logic [dobss_pkg::CODE_W-1:0]       dac_code_o,
  input logic                               slewing_o
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dac_code_o) &&
      $stable(out_channel_o) && $stable(slewing_o))
    else $error("stalled result beat changed");

  // An accepted beat reaches the output once the result register can take it.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 (!out_valid_o || out_ready_i) |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  // A free result register never blocks the input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Missing channels report zero code and no slewing.
  a_missing_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (int'(out_channel_o) >= CHANNELS) |-> (dac_code_o == '0) && !slewing_o)
    else $error("missing channel reported nonzero state");

endmodule

bind dac_offset_binary_slew_servo dobss_checker #(
  .CHANNELS(CHANNELS)
) u_dobss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_channel_o (out_channel_o),
  .dac_code_o    (dac_code_o),
  .slewing_o     (slewing_o)
);

FILE: tb/sv/tb_dac_offset_binary_slew_servo.sv
// Self-checking testbench for the per-channel binary-slew DAC offset servo.
`timescale 1ns / 1ps

module tb_dac_offset_binary_slew_servo;
  import dobss_pkg::*;

  localparam int NUM_CH      = CHANNELS_DEF;
  localparam int NUM_STEPS   = STEPS_DEF;
  localparam int DIR_ROWS    = 25;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 160;

  // Indexes past the register map; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef enum int {SK_SLEW_OUT, SK_SLEW_IN, SK_SETTLED_OUT, SK_ANY} samp_kind_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] sample;
    logic [CODE_W-1:0]   ovr;
    logic                typed;
    logic [CODE_W-1:0]   t_code;
    logic                t_slew;
  } stim_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [CODE_W-1:0] code;
    logic              slew;
  } dac_result_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready_o;
  cmd_e                  in_cmd    = CMD_SAMPLE;
  logic [CHAN_W-1:0]     in_chan   = '0;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic [CODE_W-1:0]     in_ovr    = '0;
  logic                  in_typed  = 1'b0;
  logic [CODE_W-1:0]     typed_code = '0;
  logic                  typed_slew = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  logic [CHAN_W-1:0]     out_channel_o;
  logic [CODE_W-1:0]     dac_code_o;
  logic                  slewing_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int err_cnt        = 0;

  // Thresholds the stimulus aims at; the predictor keeps its own copy.
  cfg_t cur_cfg = '{SETTLED_UPPER_RST, SETTLED_LOWER_RST, SLEW_DONE_UPPER_RST,
                    SLEW_DONE_LOWER_RST, MID_LEVEL_RST, RESET_CODE};

  cfg_t                  pred_cfg;
  logic                  pred_slew [NUM_CH];
  logic [STEP_IDX_W-1:0] pred_step [NUM_CH];
  logic [CODE_W-1:0]     pred_code [NUM_CH];
  dac_result_t           pending_codes [$];

  // Reset thresholds throughout; rows with typed=0 are checked by the predictor.
  stim_t dir_tab [DIR_ROWS] = '{
    '{CMD_SAMPLE,   3'd0, 16'd30000, 12'd0,    1'b1, 12'd2048, 1'b0},
    '{CMD_SAMPLE,   3'd1, 16'd65535, 12'd4095, 1'b1, 12'd1024, 1'b1},
    '{CMD_SAMPLE,   3'd2, 16'd0,     12'd0,    1'b1, 12'd3072, 1'b1},
    '{CMD_OVERRIDE, 3'd3, 16'd0,     12'd4095, 1'b1, 12'd4095, 1'b1},
    '{CMD_OVERRIDE, 3'd4, 16'd65535, 12'd0,    1'b1, 12'd0,    1'b1},
    '{CMD_SAMPLE,   3'd4, 16'd65535, 12'd0,    1'b1, 12'd0,    1'b1},
    '{CMD_SAMPLE,   3'd3, 16'd0,     12'd0,    1'b1, 12'd4095, 1'b1},
    '{CMD_SAMPLE,   3'd0, 16'd65535, 12'd0,    1'b1, 12'd2048, 1'b1},
    '{CMD_SAMPLE,   3'd6, 16'd40000, 12'd0,    1'b1, 12'd1024, 1'b1},
    '{CMD_SAMPLE,   3'd7, 16'd26000, 12'd0,    1'b1, 12'd3072, 1'b1},
    '{CMD_SAMPLE,   3'd6, 16'd39999, 12'd0,    1'b1, 12'd1024, 1'b0},
    '{CMD_SAMPLE,   3'd6, 16'd500,   12'd0,    1'b1, 12'd2048, 1'b1},
    '{CMD_OVERRIDE, 3'd7, 16'd0,     12'd100,  1'b1, 12'd100,  1'b1},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b1, 12'd4095, 1'b1},
    '{CMD_SAMPLE,   3'd5, 16'd0,     12'd0,    1'b1, 12'd2048, 1'b1}
  };

  dac_offset_binary_slew_servo #(
    .CHANNELS(NUM_CH),
    .STEPS   (NUM_STEPS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .cmd_i          (in_cmd),
    .channel_i      (in_chan),
    .sample_i       (in_sample),
    .override_code_i(in_ovr),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_channel_o  (out_channel_o),
    .dac_code_o     (dac_code_o),
    .slewing_o      (slewing_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  function automatic void chan_restart(input logic [CHAN_W-1:0] ch);
    pred_slew[ch] = 1'b1;
    pred_step[ch] = '0;
    pred_code[ch] = pred_cfg.start_code;
  endfunction

  function automatic void chan_settle(input logic [CHAN_W-1:0] ch);
    pred_slew[ch] = 1'b0;
    pred_step[ch] = '0;
  endfunction

  function automatic dac_result_t servo_predict(input cmd_e cmd, input logic [CHAN_W-1:0] ch,
                                                input logic [SAMPLE_W-1:0] s,
                                                input logic [CODE_W-1:0] ov);
    dac_result_t r;
    int          k;
    int          size;
    int          code;
    logic        slew_out;
    r.chan = ch;
    r.code = '0;
    r.slew = 1'b0;
    if (int'(ch) >= NUM_CH) return r;
    if (cmd == CMD_OVERRIDE) begin
      pred_code[ch] = ov;
    end else if (!pred_slew[ch]) begin
      if (s >= pred_cfg.settled_upper || s <= pred_cfg.settled_lower) chan_restart(ch);
    end else begin
      slew_out = (s >= pred_cfg.slew_done_upper) || (s <= pred_cfg.slew_done_lower);
      k = int'(pred_step[ch]);
      if (k >= NUM_STEPS) begin
        if (slew_out) chan_restart(ch);
        else chan_settle(ch);
      end else if (slew_out) begin
        size = (k < 12) ? (int'(FIRST_STEP) >> k) : 0;
        code = int'(pred_code[ch]);
        code = (s >= pred_cfg.mid_level) ? code - size : code + size;
        if (code < 0) code = 0;
        if (code > int'(CODE_MAX)) code = int'(CODE_MAX);
        pred_code[ch] = CODE_W'(code);
        pred_step[ch] = STEP_IDX_W'(k + 1);
      end else begin
        chan_settle(ch);
      end
    end
    r.code = pred_code[ch];
    r.slew = pred_slew[ch];
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input samp_kind_e kind);
    int lo;
    int hi;
    case (kind)
      SK_SLEW_OUT: begin
        if ($urandom_range(1)) return SAMPLE_W'($urandom_range(65535, cur_cfg.slew_done_upper));
        return SAMPLE_W'($urandom_range(cur_cfg.slew_done_lower, 0));
      end
      SK_SETTLED_OUT: begin
        if ($urandom_range(1)) return SAMPLE_W'($urandom_range(65535, cur_cfg.settled_upper));
        return SAMPLE_W'($urandom_range(cur_cfg.settled_lower, 0));
      end
      SK_SLEW_IN: begin
        lo = int'(cur_cfg.slew_done_lower) + 1;
        hi = int'(cur_cfg.slew_done_upper) - 1;
        if (lo <= hi) return SAMPLE_W'($urandom_range(hi, lo));
        return SAMPLE_W'($urandom_range(65535));
      end
      default: return SAMPLE_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic stim_t make_sample(input logic [CHAN_W-1:0] ch, input samp_kind_e kind);
    stim_t it;
    it.cmd    = CMD_SAMPLE;
    it.chan   = ch;
    it.sample = pick_sample(kind);
    it.ovr    = CODE_W'($urandom_range(4095));
    it.typed  = 1'b0;
    it.t_code = '0;
    it.t_slew = 1'b0;
    return it;
  endfunction

  // Call at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(input stim_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    in_cmd     <= it.cmd;
    in_chan    <= it.chan;
    in_sample  <= it.sample;
    in_ovr     <= it.ovr;
    in_typed   <= it.typed;
    typed_code <= it.t_code;
    typed_slew <= it.t_slew;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on every input beat, compare on every output beat.
  always @(posedge clk_i) begin
    dac_result_t pred;
    dac_result_t want;
    if (!rst_ni) begin
      pred_cfg = '{SETTLED_UPPER_RST, SETTLED_LOWER_RST, SLEW_DONE_UPPER_RST,
                   SLEW_DONE_LOWER_RST, MID_LEVEL_RST, RESET_CODE};
      for (int c = 0; c < NUM_CH; c++) begin
        pred_slew[c] = 1'b1;
        pred_step[c] = '0;
        pred_code[c] = RESET_CODE;
      end
    end else begin
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          REG_SETTLED_UPPER:   pred_cfg.settled_upper   = cfg_data;
          REG_SETTLED_LOWER:   pred_cfg.settled_lower   = cfg_data;
          REG_SLEW_DONE_UPPER: pred_cfg.slew_done_upper = cfg_data;
          REG_SLEW_DONE_LOWER: pred_cfg.slew_done_lower = cfg_data;
          REG_MID_LEVEL:       pred_cfg.mid_level       = cfg_data;
          REG_START_CODE:      pred_cfg.start_code      = cfg_data[CODE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready_o) begin
        pred = servo_predict(in_cmd, in_chan, in_sample, in_ovr);
        if (in_typed) begin
          pred.code = typed_code;
          pred.slew = typed_slew;
        end
        pending_codes.push_back(pred);
      end
      if (out_valid_o && out_ready) begin
        if (pending_codes.size() == 0) begin
          $error("unexpected beat: out_channel %0d dac_code %0d slewing %0d",
                 out_channel_o, dac_code_o, slewing_o);
          err_cnt++;
        end else begin
          want = pending_codes.pop_front();
          if (out_channel_o !== want.chan) begin
            $error("out_channel: expected %0d, got %0d", want.chan, out_channel_o);
            err_cnt++;
          end
          if (dac_code_o !== want.code) begin
            $error("dac_code: expected %0d, got %0d", want.code, dac_code_o);
            err_cnt++;
          end
          if (slewing_o !== want.slew) begin
            $error("slewing: expected %0d, got %0d", want.slew, slewing_o);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned       bounds [$];
    cfg_t              nc;
    int                pick;
    int                len;
    logic [CHAN_W-1:0] ch;
    stim_t             it;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Drain and let the pipeline empty before touching the thresholds.
      in_valid <= 1'b0;
      while (pending_codes.size() != 0) @(negedge clk_i);
      repeat (4) @(negedge clk_i);

      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase

      nc = cur_cfg;
      if (p == 1) begin
        nc = '0;
      end else if (p == 2) begin
        nc = '1;
      end else if (p == 4) begin
        nc = '{SETTLED_UPPER_RST, SETTLED_LOWER_RST, SLEW_DONE_UPPER_RST,
               SLEW_DONE_LOWER_RST, MID_LEVEL_RST, RESET_CODE};
      end else if (p != 0) begin
        bounds.delete();
        repeat (5) bounds.push_back($urandom_range(65535));
        // Mostly nested windows so channels settle and restart; else anything.
        if ($urandom_range(99) < 70) bounds.sort();
        nc.settled_lower   = SAMPLE_W'(bounds[0]);
        nc.slew_done_lower = SAMPLE_W'(bounds[1]);
        nc.mid_level       = SAMPLE_W'(bounds[2]);
        nc.slew_done_upper = SAMPLE_W'(bounds[3]);
        nc.settled_upper   = SAMPLE_W'(bounds[4]);
        nc.start_code      = CODE_W'($urandom_range(4095));
      end

      if (p != 0) begin
        write_reg(REG_SETTLED_UPPER, nc.settled_upper);
        write_reg(REG_SETTLED_LOWER, nc.settled_lower);
        write_reg(REG_SLEW_DONE_UPPER, nc.slew_done_upper);
        write_reg(REG_SLEW_DONE_LOWER, nc.slew_done_lower);
        write_reg(REG_MID_LEVEL, nc.mid_level);
        write_reg(REG_START_CODE, {4'($urandom_range(15)), nc.start_code});
        if (p == 1 || p == 2 || p == 5) begin
          write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom_range(65535)));
          write_reg(REG_UNMAPPED_HI, CFG_DATA_W'($urandom_range(65535)));
        end
        cfg_valid <= 1'b0;
        cur_cfg = nc;
      end

      while (items_sent < DIR_ROWS + (p + 1) * PHASE_ITEMS) begin
        pick = $urandom_range(99);
        ch   = CHAN_W'($urandom_range(NUM_CH - 1));
        if (pick < 45) begin
          // Full or partial search run, then one sample inside or outside the slew window.
          len = $urandom_range(NUM_STEPS + 1, 1);
          repeat (len) send_item(make_sample(ch, SK_SLEW_OUT));
          if ($urandom_range(99) < 60) send_item(make_sample(ch, SK_SLEW_IN));
          else send_item(make_sample(ch, SK_SLEW_OUT));
        end else if (pick < 65) begin
          repeat ($urandom_range(4, 1)) send_item(make_sample(ch, SK_SLEW_IN));
          if ($urandom_range(1)) send_item(make_sample(ch, SK_SETTLED_OUT));
        end else if (pick < 75) begin
          it     = make_sample(ch, SK_ANY);
          it.cmd = CMD_OVERRIDE;
          send_item(it);
        end else begin
          it     = make_sample(ch, SK_ANY);
          it.cmd = cmd_e'($urandom_range(1));
          send_item(it);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/dobss_pkg.sv
rtl/core/dobss_chan_update.sv
rtl/core/dac_offset_binary_slew_servo.sv
rtl/core/dobss_checker.sv
tb/sv/tb_dac_offset_binary_slew_servo.sv
